/* sv/mrr_pkg.sv */
package mrr_pkg;

    localparam logic [15:0] CRC_INIT          = 16'hFFFF;
    localparam logic [15:0] CRC_POLY          = 16'hA001;
    localparam logic [7:0]  FUNC_READ_HOLDING = 8'h03;
    localparam logic [15:0] REG_COUNT         = 16'h0001;
    localparam logic [2:0]  RESP_LEN          = 3'd7;
    localparam logic [2:0]  RESP_DATA_HI      = 3'd3;
    localparam logic [2:0]  RESP_DATA_LO      = 3'd4;
    localparam logic [2:0]  RESP_CRC_LO       = 3'd5;
    localparam logic [2:0]  REQ_LAST          = 3'd7;
    localparam logic [7:0]  SLAVE_ADDR_RESET  = 8'd1;
    localparam logic [15:0] TIMEOUT_RESET     = 16'd300;
    localparam logic [15:0] ELAPSED_MAX       = 16'hFFFF;

    typedef enum logic [1:0] {
        OP_START   = 2'd0,
        OP_RX_BYTE = 2'd1,
        OP_TICK    = 2'd2
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_TIMEOUT = 2'd1,
        ST_CRC_ERR = 2'd2
    } t_status;

    typedef enum logic {
        KIND_TX_BYTE = 1'b0,
        KIND_REPORT  = 1'b1
    } t_kind;

    typedef enum logic {
        CFG_SLAVE_ADDRESS = 1'b0,
        CFG_TIMEOUT_TICKS = 1'b1
    } t_cfg_index;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  slave;
        logic [15:0] reg_addr;
        logic [15:0] value;
        t_status     status;
    } t_req;

    typedef struct packed {
        logic full;
        logic done;
    } t_seq_stat;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] data);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            if (crc[0]) begin
                crc = (crc >> 1) ^ CRC_POLY;
            end else begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

/* sv/mrr_tx_seq.sv */
module mrr_tx_seq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  mrr_pkg::t_req      i_req,
    output mrr_pkg::t_seq_stat o_stat,
    output logic               o_m_axis_tvalid,
    input  logic               i_m_axis_tready,
    output logic [31:0]        o_m_axis_tdata,  // tx_byte[7:0], reg_value[23:8], status[25:24]
    output logic               o_m_axis_tuser,  // kind
    output logic               o_m_axis_tlast
);
    import mrr_pkg::*;

    logic        r_pvalid;
    t_req        r_p;
    logic [2:0]  r_cnt;
    logic [15:0] r_tx_crc;
    logic        r_ovalid;
    logic [31:0] r_odata;
    logic        r_ouser;
    logic        r_olast;

    logic        w_out_free;
    logic        w_emit;
    logic        w_done;
    logic [7:0]  w_byte;
    logic [15:0] w_crc_base;
    logic        w_report;

    assign w_report   = (r_p.kind == KIND_REPORT);
    assign w_out_free = !r_ovalid || i_m_axis_tready;
    assign w_emit     = r_pvalid && w_out_free;
    assign w_done     = w_emit && (w_report || (r_cnt == REQ_LAST));
    assign w_crc_base = (r_cnt == 3'd0) ? CRC_INIT : r_tx_crc;

    always_comb begin
        unique case (r_cnt)
            3'd0: w_byte = r_p.slave;
            3'd1: w_byte = FUNC_READ_HOLDING;
            3'd2: w_byte = r_p.reg_addr[15:8];
            3'd3: w_byte = r_p.reg_addr[7:0];
            3'd4: w_byte = REG_COUNT[15:8];
            3'd5: w_byte = REG_COUNT[7:0];
            3'd6: w_byte = r_tx_crc[7:0];
            3'd7: w_byte = r_tx_crc[15:8];
            default: w_byte = 8'h00;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvalid <= 1'b0;
            r_cnt    <= 3'd0;
            r_ovalid <= 1'b0;
        end else begin
            if (w_emit) begin
                r_ovalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            if (w_emit && !w_report) begin
                r_cnt <= r_cnt + 3'd1;
            end
            if (w_done) begin
                r_pvalid <= 1'b0;
            end
            if (i_load) begin
                r_pvalid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_p <= i_req;
        end
        if (w_emit) begin
            if (w_report) begin
                r_odata <= {6'd0, r_p.status, r_p.value, 8'h00};
                r_ouser <= KIND_REPORT;
                r_olast <= 1'b1;
            end else begin
                r_odata <= {6'd0, ST_OK, 16'h0000, w_byte};
                r_ouser <= KIND_TX_BYTE;
                r_olast <= (r_cnt == REQ_LAST);
                if (r_cnt < 3'd6) begin
                    r_tx_crc <= crc_feed(w_crc_base, w_byte);
                end
            end
        end
    end

    assign o_stat.full     = r_pvalid;
    assign o_stat.done     = w_done;
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;
    assign o_m_axis_tuser  = r_ouser;
    assign o_m_axis_tlast  = r_olast;

endmodule

/* sv/modbus_rtu_register_read_master.sv */
// Modbus RTU master for a single holding-register read. Input items carry an
// opcode in tuser (start, received byte, millisecond tick). A start while idle
// queues the 8-byte request (slave address, 0x03, register address, count 1,
// CRC low then high), which leaves the result channel one byte per cycle while
// the result side accepts; the request CRC is built byte by byte in the emitter;
// inputs stall after a start until the last request byte moves to the output
// register, and longer while the result side stalls. Received bytes and ticks
// are taken one per cycle; the seventh response byte or a timeout produces one
// completion report (tuser 1, tlast 1) carrying the register value and status.
// Transaction state updates when an item transfers; its report goes to the
// emitter, then to the output register, and a waiting report holds the input
// only while the output register ahead of it still holds an unsent result.
module modbus_rtu_register_read_master (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // reg_address[15:0], rx_byte[23:16]
    input  logic [1:0]  i_s_axis_tuser,   // opcode
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // tx_byte[7:0], reg_value[23:8], status[25:24]
    output logic        o_m_axis_tuser,   // kind
    output logic        o_m_axis_tlast
);
    import mrr_pkg::*;

    logic [7:0]  r_slave_addr;
    logic [15:0] r_timeout;
    logic        r_busy;
    logic [2:0]  r_rx_count;
    logic [15:0] r_crc;
    logic [15:0] r_data_word;
    logic [7:0]  r_crc_low;
    logic [15:0] r_elapsed;

    logic        n_busy;
    logic [2:0]  n_rx_count;
    logic [15:0] n_crc;
    logic [15:0] n_data_word;
    logic [7:0]  n_crc_low;
    logic [15:0] n_elapsed;

    logic        w_accept;
    logic        w_load;
    t_req        w_req;
    t_seq_stat   w_stat;
    t_opcode     w_op;
    logic [15:0] w_reg_addr;
    logic [7:0]  w_rx;
    logic [2:0]  w_cnt_inc;
    logic        w_crc_ok;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = !w_stat.full || w_stat.done;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_op            = t_opcode'(i_s_axis_tuser);
    assign w_reg_addr      = i_s_axis_tdata[15:0];
    assign w_rx            = i_s_axis_tdata[23:16];
    assign w_cnt_inc       = r_rx_count + 3'd1;
    assign w_crc_ok        = (r_crc_low == r_crc[7:0]) && (w_rx == r_crc[15:8]);

    always_comb begin
        n_busy         = r_busy;
        n_rx_count     = r_rx_count;
        n_crc          = r_crc;
        n_data_word    = r_data_word;
        n_crc_low      = r_crc_low;
        n_elapsed      = r_elapsed;
        w_load         = 1'b0;
        w_req.kind     = KIND_REPORT;
        w_req.slave    = r_slave_addr;
        w_req.reg_addr = w_reg_addr;
        w_req.value    = 16'h0000;
        w_req.status   = ST_OK;
        if (w_accept) begin
            unique case (w_op)
                OP_START: begin
                    if (!r_busy) begin
                        w_load      = 1'b1;
                        w_req.kind  = KIND_TX_BYTE;
                        n_busy      = 1'b1;
                        n_rx_count  = 3'd0;
                        n_crc       = CRC_INIT;
                        n_data_word = 16'h0000;
                        n_crc_low   = 8'h00;
                        n_elapsed   = 16'h0000;
                    end
                end
                OP_RX_BYTE: begin
                    if (r_busy) begin
                        if (r_rx_count < RESP_CRC_LO) begin
                            n_crc = crc_feed(r_crc, w_rx);
                        end
                        if (r_rx_count == RESP_DATA_HI) begin
                            n_data_word = {w_rx, r_data_word[7:0]};
                        end else if (r_rx_count == RESP_DATA_LO) begin
                            n_data_word = {r_data_word[15:8], w_rx};
                        end else if (r_rx_count == RESP_CRC_LO) begin
                            n_crc_low = w_rx;
                        end
                        n_rx_count = w_cnt_inc;
                        if (w_cnt_inc == RESP_LEN) begin
                            w_load       = 1'b1;
                            w_req.value  = w_crc_ok ? r_data_word : 16'h0000;
                            w_req.status = w_crc_ok ? ST_OK : ST_CRC_ERR;
                            n_busy       = 1'b0;
                            n_rx_count   = 3'd0;
                        end
                    end
                end
                OP_TICK: begin
                    if (r_busy) begin
                        if (r_elapsed != ELAPSED_MAX) begin
                            n_elapsed = r_elapsed + 16'd1;
                        end
                        if (n_elapsed >= r_timeout) begin
                            w_load       = 1'b1;
                            w_req.status = ST_TIMEOUT;
                            n_busy       = 1'b0;
                            n_rx_count   = 3'd0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slave_addr <= SLAVE_ADDR_RESET;
            r_timeout    <= TIMEOUT_RESET;
            r_busy       <= 1'b0;
            r_rx_count   <= 3'd0;
            r_crc        <= CRC_INIT;
            r_data_word  <= 16'h0000;
            r_crc_low    <= 8'h00;
            r_elapsed    <= 16'h0000;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (t_cfg_index'(i_cfg_index))
                    CFG_SLAVE_ADDRESS: r_slave_addr <= i_cfg_data[7:0];
                    CFG_TIMEOUT_TICKS: r_timeout    <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            r_busy      <= n_busy;
            r_rx_count  <= n_rx_count;
            r_crc       <= n_crc;
            r_data_word <= n_data_word;
            r_crc_low   <= n_crc_low;
            r_elapsed   <= n_elapsed;
        end
    end

    mrr_tx_seq u_tx_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (w_load),
        .i_req           (w_req),
        .o_stat          (w_stat),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    a_report_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> o_m_axis_tlast)
        else $error("completion report without tlast");

    a_tx_byte_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser |-> o_m_axis_tdata[31:8] == 24'h0)
        else $error("request byte carries value or status");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && (w_op == OP_START) && !r_busy |=> r_busy)
        else $error("start while idle did not open a transaction");

    a_rx_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rx_count != RESP_LEN)
        else $error("response byte count overran");

endmodule

/* tb/modbus_rtu_register_read_master_test.sv */
module modbus_rtu_register_read_master_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mrr_pkg::*;

    localparam logic [1:0] OP_UNUSED       = 2'd3;
    localparam logic [7:0] RESP_BYTE_COUNT = 8'h02;
    localparam int         QUIET_LIMIT     = 4000;
    localparam int         HOLD_CYCLES     = 150;
    localparam int         SETTLE_CYCLES   = 8;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] reg_addr;
        logic [7:0]  rx;
    } t_bus_event;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  tx_byte;
        logic        last;
        logic [15:0] reg_value;
        t_status     status;
    } t_bus_word;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_cfg_valid     = 1'b0;
    logic        o_cfg_ready;
    t_cfg_index  i_cfg_index     = CFG_SLAVE_ADDRESS;
    logic [15:0] i_cfg_data      = '0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [23:0] i_s_axis_tdata  = '0;
    logic [1:0]  i_s_axis_tuser  = '0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [31:0] o_m_axis_tdata;
    logic        o_m_axis_tuser;
    logic        o_m_axis_tlast;

    modbus_rtu_register_read_master i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #2 i_clk = ~i_clk;

    t_bus_event bus_events_pending[$];
    t_bus_word  bus_words_due[$];
    t_bus_event drv_event;
    t_bus_word  seen_word;

    int events_queued   = 0;
    int events_taken    = 0;
    int fails           = 0;
    int quiet_cycles    = 0;
    int hold_left       = 0;
    bit hold_used       = 1'b0;
    bit hold_arm        = 1'b0;
    bit send_gaps       = 1'b1;
    bit recv_gaps       = 1'b1;

    // stimulus-side copy of the settings
    logic [7:0]  gen_slave   = SLAVE_ADDR_RESET;
    logic [15:0] gen_timeout = TIMEOUT_RESET;

    // mirror of the master
    logic [7:0]  mirror_slave   = SLAVE_ADDR_RESET;
    logic [15:0] mirror_timeout = TIMEOUT_RESET;
    logic        txn_open       = 1'b0;
    logic [2:0]  resp_idx       = '0;
    logic [15:0] resp_crc       = CRC_INIT;
    logic [15:0] resp_word      = '0;
    logic [7:0]  resp_crc_lo    = '0;
    logic [15:0] tick_count     = '0;

    int frames_requested = 0;
    int reports_ok       = 0;
    int reports_timeout  = 0;
    int reports_crc      = 0;

    function automatic logic [15:0] crc16_shift(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        r = c ^ {8'h00, b};
        repeat (8) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        return r;
    endfunction

    function automatic void push_word(input t_kind kind, input logic [7:0] tx, input logic last,
                                      input logic [15:0] val, input t_status st);
        t_bus_word w;
        w.kind      = kind;
        w.tx_byte   = tx;
        w.last      = last;
        w.reg_value = val;
        w.status    = st;
        bus_words_due.push_back(w);
    endfunction

    task automatic master_step(input logic [1:0] op, input logic [15:0] addr,
                               input logic [7:0] rx);
        logic [7:0]  frame [8];
        logic [15:0] c;
        logic        ok;
        case (op)
            OP_START: begin
                if (!txn_open) begin
                    frame[0] = mirror_slave;
                    frame[1] = FUNC_READ_HOLDING;
                    frame[2] = addr[15:8];
                    frame[3] = addr[7:0];
                    frame[4] = REG_COUNT[15:8];
                    frame[5] = REG_COUNT[7:0];
                    c = CRC_INIT;
                    for (int k = 0; k < 6; k++) c = crc16_shift(c, frame[k]);
                    frame[6] = c[7:0];
                    frame[7] = c[15:8];
                    for (int k = 0; k < 8; k++)
                        push_word(KIND_TX_BYTE, frame[k], k == REQ_LAST, '0, ST_OK);
                    txn_open   = 1'b1;
                    resp_idx   = '0;
                    resp_crc   = CRC_INIT;
                    resp_word  = '0;
                    resp_crc_lo = '0;
                    tick_count = '0;
                    frames_requested++;
                end
            end
            OP_RX_BYTE: begin
                if (txn_open) begin
                    if (resp_idx < RESP_CRC_LO) resp_crc = crc16_shift(resp_crc, rx);
                    if (resp_idx == RESP_DATA_HI) resp_word[15:8] = rx;
                    else if (resp_idx == RESP_DATA_LO) resp_word[7:0] = rx;
                    else if (resp_idx == RESP_CRC_LO) resp_crc_lo = rx;
                    resp_idx = resp_idx + 3'd1;
                    if (resp_idx == RESP_LEN) begin
                        ok = (resp_crc_lo == resp_crc[7:0]) && (rx == resp_crc[15:8]);
                        push_word(KIND_REPORT, '0, 1'b1, ok ? resp_word : 16'h0000,
                                  ok ? ST_OK : ST_CRC_ERR);
                        if (ok) reports_ok++;
                        else reports_crc++;
                        txn_open = 1'b0;
                        resp_idx = '0;
                    end
                end
            end
            OP_TICK: begin
                if (txn_open) begin
                    if (tick_count != ELAPSED_MAX) tick_count = tick_count + 16'd1;
                    if (tick_count >= mirror_timeout) begin
                        push_word(KIND_REPORT, '0, 1'b1, '0, ST_TIMEOUT);
                        reports_timeout++;
                        txn_open = 1'b0;
                        resp_idx = '0;
                    end
                end
            end
            default: begin
            end
        endcase
    endtask

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else if (!i_s_axis_tvalid || o_s_axis_tready) begin
            if (bus_events_pending.size() != 0 && !(send_gaps && $urandom_range(99) < 35)) begin
                drv_event = bus_events_pending.pop_front();
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata  <= {drv_event.rx, drv_event.reg_addr};
                i_s_axis_tuser  <= drv_event.op;
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else if (hold_arm && !hold_used) begin
            hold_used       <= 1'b1;
            hold_left       <= HOLD_CYCLES;
            i_m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left       <= hold_left - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= !(recv_gaps && $urandom_range(99) < 35);
        end
    end

    // monitor: predict on input transfers, check output transfers
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SLAVE_ADDRESS: mirror_slave   = i_cfg_data[7:0];
                    CFG_TIMEOUT_TICKS: mirror_timeout = i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                master_step(i_s_axis_tuser, i_s_axis_tdata[15:0], i_s_axis_tdata[23:16]);
                events_taken++;
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (bus_words_due.size() == 0) begin
                    $error("unexpected transfer on result side: tdata %h tuser %b",
                           o_m_axis_tdata, o_m_axis_tuser);
                    fails++;
                end else begin
                    seen_word = bus_words_due.pop_front();
                    if (o_m_axis_tuser !== seen_word.kind) begin
                        $error("kind: expected %0d, got %0d", seen_word.kind, o_m_axis_tuser);
                        fails++;
                    end
                    if (o_m_axis_tdata[7:0] !== seen_word.tx_byte) begin
                        $error("tx_byte: expected %h, got %h",
                               seen_word.tx_byte, o_m_axis_tdata[7:0]);
                        fails++;
                    end
                    if (o_m_axis_tlast !== seen_word.last) begin
                        $error("last: expected %0d, got %0d", seen_word.last, o_m_axis_tlast);
                        fails++;
                    end
                    if (o_m_axis_tdata[23:8] !== seen_word.reg_value) begin
                        $error("reg_value: expected %h, got %h",
                               seen_word.reg_value, o_m_axis_tdata[23:8]);
                        fails++;
                    end
                    if (o_m_axis_tdata[25:24] !== seen_word.status) begin
                        $error("status: expected %0d, got %0d",
                               seen_word.status, o_m_axis_tdata[25:24]);
                        fails++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)
                    || (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("no transfer for %0d cycles, %0d results outstanding",
                         quiet_cycles, bus_words_due.size());
                $display("== FAIL ==");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    function automatic void push_event(input logic [1:0] op, input logic [15:0] addr,
                                       input logic [7:0] rx);
        t_bus_event e;
        e.op       = op;
        e.reg_addr = addr;
        e.rx       = rx;
        bus_events_pending.push_back(e);
        events_queued++;
    endfunction

    task automatic push_reply(input logic [7:0] addr_byte, input logic [15:0] val,
                              input int bad_pos, input bit tick_mix);
        logic [7:0]  b [7];
        logic [15:0] c;
        b[0] = addr_byte;
        b[1] = FUNC_READ_HOLDING;
        b[2] = RESP_BYTE_COUNT;
        b[3] = val[15:8];
        b[4] = val[7:0];
        c = CRC_INIT;
        for (int k = 0; k < 5; k++) c = crc16_shift(c, b[k]);
        b[5] = c[7:0];
        b[6] = c[15:8];
        if (bad_pos >= 0) b[bad_pos] = b[bad_pos] ^ (8'h01 << $urandom_range(7));
        for (int k = 0; k < 7; k++) begin
            if (tick_mix && $urandom_range(9) == 0)
                push_event(OP_TICK, 16'($urandom), 8'($urandom));
            push_event(OP_RX_BYTE, 16'($urandom), b[k]);
        end
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [15:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // wait until the master is idle; close any open transaction with filler bytes
    task automatic settle();
        bit again;
        again = 1'b1;
        while (again) begin
            while (events_taken != events_queued || bus_words_due.size() != 0)
                @(posedge i_clk);
            repeat (SETTLE_CYCLES) @(posedge i_clk);
            again = txn_open;
            if (again)
                for (int k = 0; k < 7; k++)
                    push_event(OP_RX_BYTE, 16'($urandom), 8'($urandom));
        end
    endtask

    task automatic random_traffic(input int n);
        int first;
        int r;
        first = events_queued;
        while (events_queued - first < n) begin
            r = $urandom_range(99);
            if (r < 65) begin
                push_event(OP_START, 16'($urandom), 8'($urandom));
                push_reply($urandom_range(3) == 0 ? 8'($urandom) : gen_slave, 16'($urandom),
                           $urandom_range(3) == 0 ? int'($urandom_range(6)) : -1, 1'b1);
            end else if (r < 80) begin
                push_event(OP_START, 16'($urandom), 8'($urandom));
                repeat ($urandom_range(3))
                    push_event(OP_RX_BYTE, 16'($urandom), 8'($urandom));
                repeat (gen_timeout <= 64 ? int'(gen_timeout) : 5)
                    push_event(OP_TICK, 16'($urandom), 8'($urandom));
            end else begin
                repeat ($urandom_range(1, 4))
                    push_event(2'($urandom), 16'($urandom), 8'($urandom));
            end
        end
    endtask

    task automatic run_phase(input logic [7:0] sa, input logic [15:0] to, input bit gaps,
                             input bit squeeze, input int n);
        write_reg(CFG_SLAVE_ADDRESS, {8'h00, sa});
        write_reg(CFG_TIMEOUT_TICKS, to);
        gen_slave   = sa;
        gen_timeout = to;
        send_gaps <= gaps;
        recv_gaps <= gaps;
        if (squeeze) hold_arm <= 1'b1;
        random_traffic(n);
        settle();
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // idle master ignores ticks, bytes and the unused opcode
        push_event(OP_TICK, 16'h0000, 8'h00);
        push_event(OP_RX_BYTE, 16'hFFFF, 8'hFF);
        push_event(OP_UNUSED, 16'hFFFF, 8'hFF);
        push_event(OP_START, 16'h0000, 8'h00);
        push_event(OP_START, 16'hFFFF, 8'hFF);
        push_event(OP_UNUSED, 16'h0000, 8'h00);
        push_event(OP_TICK, 16'hFFFF, 8'hFF);
        push_reply(SLAVE_ADDR_RESET, 16'h0000, -1, 1'b0);
        push_event(OP_RX_BYTE, 16'h0000, 8'h55);
        push_event(OP_START, 16'hFFFF, 8'h00);
        push_reply(SLAVE_ADDR_RESET, 16'hFFFF, 6, 1'b0);
        settle();

        write_reg(CFG_SLAVE_ADDRESS, 16'h0000);
        write_reg(CFG_TIMEOUT_TICKS, 16'd1);
        gen_slave   = 8'h00;
        gen_timeout = 16'd1;
        push_event(OP_START, 16'h1234, 8'h00);
        push_event(OP_TICK, 16'h0000, 8'h00);
        push_event(OP_START, 16'h8001, 8'h00);
        push_event(OP_RX_BYTE, 16'h0000, 8'h00);
        push_event(OP_RX_BYTE, 16'h0000, 8'h03);
        push_event(OP_TICK, 16'h0000, 8'h00);
        settle();

        run_phase(8'hFF, 16'hFFFF, 1'b1, 1'b0, 20);
        run_phase(8'($urandom), 16'd3, 1'b0, 1'b1, 20);
        run_phase(8'($urandom), 16'($urandom_range(8, 40)), 1'b1, 1'b0, 20);
        run_phase(8'($urandom), TIMEOUT_RESET, 1'b1, 1'b0, 20);

        $display("%0d input transfers, %0d requests sent", events_taken, frames_requested);
        $display("reports: %0d ok, %0d timeout, %0d crc error",
                 reports_ok, reports_timeout, reports_crc);
        if (fails == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
